// ===== rtl/triangle_area_3d_assert.svh =====
// Assertion macros shared by the triangle area checker.
`ifndef TRIANGLE_AREA_3D_ASSERT_SVH
`define TRIANGLE_AREA_3D_ASSERT_SVH

// same-cycle implication
`define TA3_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define TA3_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/ta3_pkg.sv =====
// Shared types and constants for the triangle area datapath.
`default_nettype none
package ta3_pkg;
    localparam int AREA_BITS = 50;
    localparam int SUM_FRAC_BITS = 32;
    localparam logic [AREA_BITS-1:0] AREA_ONE = AREA_BITS'(65536);

    typedef struct packed {
        logic valid;
        logic degen;
    } ctl_t;
endpackage
`default_nettype wire

// ===== rtl/ta3_front.sv =====
// Front pipeline: edge vectors, cross product, squared length, scaling.
`default_nettype none
module ta3_front
    import ta3_pkg::*;
#(
    parameter int CB  = 24,
    parameter int FB  = 8,
    parameter int SQW = 104
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 tri_valid,
    input  wire logic [CB-1:0]        ax,
    input  wire logic [CB-1:0]        ay,
    input  wire logic [CB-1:0]        az,
    input  wire logic [CB-1:0]        bx,
    input  wire logic [CB-1:0]        by_coord,
    input  wire logic [CB-1:0]        bz,
    input  wire logic [CB-1:0]        cx,
    input  wire logic [CB-1:0]        cy,
    input  wire logic [CB-1:0]        cz,
    output ctl_t                      ctl,
    output logic [SQW-1:0]            rad
);
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * DW;
    localparam int CW   = PW + 1;
    localparam int LW   = (CW + 1) / 2;
    localparam int HW   = CW - LW;
    localparam int QW   = 2 * CW;
    localparam int SUMW = QW + 2;
    localparam int SH   = SUM_FRAC_BITS - 4 * FB;
    localparam int SHL  = (SH > 0) ? SH : 0;
    localparam int SHR  = (SH < 0) ? -SH : 0;
    localparam int RADW = SUMW + SHL;

    ctl_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [PW-1:0] m_reg [6];
    logic [CW-1:0]        mag_reg [3];
    logic [2*HW-1:0]      hh_reg [3];
    logic [HW+LW-1:0]     hl_reg [3];
    logic [2*LW-1:0]      ll_reg [3];
    logic [QW-1:0]        sq_reg [3];
    logic [SQW-1:0]       rad_reg;

    logic signed [DW-1:0] pa [3];
    logic signed [DW-1:0] pb [3];
    logic signed [DW-1:0] pc [3];
    logic signed [CW-1:0] cr [3];
    logic [SUMW-1:0]      sum;
    logic [RADW-1:0]      scaled;

    assign pa[0] = DW'(signed'(ax));
    assign pa[1] = DW'(signed'(ay));
    assign pa[2] = DW'(signed'(az));
    assign pb[0] = DW'(signed'(bx));
    assign pb[1] = DW'(signed'(by_coord));
    assign pb[2] = DW'(signed'(bz));
    assign pc[0] = DW'(signed'(cx));
    assign pc[1] = DW'(signed'(cy));
    assign pc[2] = DW'(signed'(cz));

    assign cr[0] = CW'(m_reg[0]) - CW'(m_reg[1]);
    assign cr[1] = CW'(m_reg[2]) - CW'(m_reg[3]);
    assign cr[2] = CW'(m_reg[4]) - CW'(m_reg[5]);

    assign sum = SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);

    always_comb
    begin
        if (SHL > 0)
        begin
            scaled = RADW'(sum) << SHL;
        end
        else
        begin
            scaled = RADW'(sum >> SHR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (en)
        begin
            c1_reg.valid <= tri_valid;
            c1_reg.degen <= (ax == bx) && (ay == by_coord) && (az == bz);
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
            c6_reg <= c5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= pa[i] - pb[i];
                v_reg[i] <= pc[i] - pb[i];
            end
            m_reg[0] <= PW'(u_reg[1]) * PW'(v_reg[2]);
            m_reg[1] <= PW'(u_reg[2]) * PW'(v_reg[1]);
            m_reg[2] <= PW'(u_reg[2]) * PW'(v_reg[0]);
            m_reg[3] <= PW'(u_reg[0]) * PW'(v_reg[2]);
            m_reg[4] <= PW'(u_reg[0]) * PW'(v_reg[1]);
            m_reg[5] <= PW'(u_reg[1]) * PW'(v_reg[0]);
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= cr[i][CW-1] ? CW'(-cr[i]) : CW'(cr[i]);
                hh_reg[i] <= (2*HW)'(mag_reg[i][CW-1:LW]) * (2*HW)'(mag_reg[i][CW-1:LW]);
                hl_reg[i] <= (HW+LW)'(mag_reg[i][CW-1:LW]) * (HW+LW)'(mag_reg[i][LW-1:0]);
                ll_reg[i] <= (2*LW)'(mag_reg[i][LW-1:0]) * (2*LW)'(mag_reg[i][LW-1:0]);
                sq_reg[i] <= (QW'(hh_reg[i]) << (2*LW)) + (QW'(hl_reg[i]) << (LW+1))
                             + QW'(ll_reg[i]);
            end
            rad_reg <= SQW'(scaled);
        end
    end

    assign ctl = c6_reg;
    assign rad = rad_reg;
endmodule
`default_nettype wire

// ===== rtl/ta3_sqrt_cell.sv =====
// One cell of the square root chain: resolves one root bit per cycle while en is high.
`default_nettype none
module ta3_sqrt_cell
    import ta3_pkg::*;
#(
    parameter int RW = 52
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire ctl_t             ctl_in,
    input  wire logic [RW+1:0]    rem_in,
    input  wire logic [RW-1:0]    q_in,
    input  wire logic [2*RW-1:0]  x_in,
    output ctl_t                  ctl_out,
    output logic [RW+1:0]         rem_out,
    output logic [RW-1:0]         q_out,
    output logic [2*RW-1:0]       x_out
);
    ctl_t               ctl_reg;
    logic [RW+1:0]      rem_reg;
    logic [RW-1:0]      q_reg;
    logic [2*RW-1:0]    x_reg;

    logic [RW+3:0]      tmp;
    logic [RW+3:0]      trial;
    logic               ge;

    assign tmp   = {rem_in, x_in[2*RW-1:2*RW-2]};
    assign trial = (RW+4)'({q_in, 2'b01});
    assign ge    = (tmp >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? (RW+2)'(tmp - trial) : (RW+2)'(tmp);
            q_reg   <= {q_in[RW-2:0], ge};
            x_reg   <= {x_in[2*RW-3:0], 2'b00};
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign x_out   = x_reg;
endmodule
`default_nettype wire

// ===== rtl/triangle_area_3d.sv =====
// Front stages feed a square root chain of RW cells, where RW is the root width,
// one chain cell per root bit; the chain feeds the registered area word.
// Throughput: one triangle per cycle; the whole pipeline holds while a finished
// area word is stalled.
// Reset clears every valid bit at once; data registers are not reset.
`default_nettype none
module triangle_area_3d
    import ta3_pkg::*;
#(
    parameter int COORD_BITS      = 24,
    parameter int COORD_FRAC_BITS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  tri_valid,
    output logic                       tri_stall,
    input  wire logic [COORD_BITS-1:0] ax,
    input  wire logic [COORD_BITS-1:0] ay,
    input  wire logic [COORD_BITS-1:0] az,
    input  wire logic [COORD_BITS-1:0] bx,
    input  wire logic [COORD_BITS-1:0] by_coord,
    input  wire logic [COORD_BITS-1:0] bz,
    input  wire logic [COORD_BITS-1:0] cx,
    input  wire logic [COORD_BITS-1:0] cy,
    input  wire logic [COORD_BITS-1:0] cz,
    output logic                       area_valid,
    input  wire logic                  area_stall,
    output logic [AREA_BITS-1:0]       area,
    output logic                       degenerate_base
);
    localparam int CW   = 2 * (COORD_BITS + 1) + 1;
    localparam int SUMW = 2 * CW + 2;
    localparam int SH   = SUM_FRAC_BITS - 4 * COORD_FRAC_BITS;
    localparam int SHL  = (SH > 0) ? SH : 0;
    localparam int RW   = (SUMW + SHL + 1) / 2;
    localparam int SQW  = 2 * RW;

    logic en;
    ctl_t              ctl_c [RW+1];
    logic [RW+1:0]     rem_c [RW+1];
    logic [RW-1:0]     q_c   [RW+1];
    logic [SQW-1:0]    x_c   [RW+1];

    logic                  valid_reg, valid_next;
    logic [AREA_BITS-1:0]  area_reg, area_next;
    logic                  degen_reg;
    logic [RW-1:0]         half;

    assign en        = !(valid_reg && area_stall);
    assign tri_stall = !en;

    ta3_front #(.CB(COORD_BITS), .FB(COORD_FRAC_BITS), .SQW(SQW)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .tri_valid(tri_valid),
        .ax       (ax),
        .ay       (ay),
        .az       (az),
        .bx       (bx),
        .by_coord (by_coord),
        .bz       (bz),
        .cx       (cx),
        .cy       (cy),
        .cz       (cz),
        .ctl      (ctl_c[0]),
        .rad      (x_c[0])
    );

    assign rem_c[0] = '0;
    assign q_c[0]   = '0;

    for (genvar g = 0; g < RW; g++)
    begin : g_cell
        ta3_sqrt_cell #(.RW(RW)) u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl_in (ctl_c[g]),
            .rem_in (rem_c[g]),
            .q_in   (q_c[g]),
            .x_in   (x_c[g]),
            .ctl_out(ctl_c[g+1]),
            .rem_out(rem_c[g+1]),
            .q_out  (q_c[g+1]),
            .x_out  (x_c[g+1])
        );
    end

    assign half = q_c[RW] >> 1;

    always_comb
    begin
        valid_next = en ? ctl_c[RW].valid : valid_reg;
        if (ctl_c[RW].degen)
        begin
            area_next = AREA_ONE;
        end
        else if ((half >> AREA_BITS) != '0)
        begin
            area_next = '1;
        end
        else
        begin
            area_next = AREA_BITS'(half);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            area_reg  <= area_next;
            degen_reg <= ctl_c[RW].degen;
        end
    end

    assign area_valid      = valid_reg;
    assign area            = area_reg;
    assign degenerate_base = degen_reg;
endmodule
`default_nettype wire

// ===== rtl/ta3_checker.sv =====
// Port-level checker for the triangle area block, bound to the top level.
`default_nettype none
`include "triangle_area_3d_assert.svh"
module ta3_checker
    import ta3_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 tri_stall,
    input wire logic                 area_valid,
    input wire logic                 area_stall,
    input wire logic [AREA_BITS-1:0] area,
    input wire logic                 degenerate_base
);
    `TA3_ASSERT_NOW(a_degen_one, area_valid && degenerate_base, area == AREA_ONE, "degenerate area not one")
    `TA3_ASSERT_NOW(a_stall_cause, tri_stall, area_valid && area_stall, "input stalled without output stall")
    `TA3_ASSERT_NEXT(a_hold_word, area_valid && area_stall, area_valid && $stable(area), "stalled word changed")
    `TA3_ASSERT_NEXT(a_hold_flag, area_valid && area_stall, $stable(degenerate_base), "stalled flag changed")
endmodule

bind triangle_area_3d ta3_checker u_ta3_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .tri_stall      (tri_stall),
    .area_valid     (area_valid),
    .area_stall     (area_stall),
    .area           (area),
    .degenerate_base(degenerate_base)
);
`default_nettype wire

// ===== sim/tb_triangle_area_3d.sv =====
// Self-checking testbench for the triangle area block: queued stimulus, predicted words, checks.
module tb_triangle_area_3d;
    import ta3_pkg::*;

    localparam int CB = 24;
    localparam logic [CB-1:0] CMAX = 24'h7FFFFF;
    localparam logic [CB-1:0] CMIN = 24'h800000;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [CB-1:0] p [9];
        int            phase;
        bit            pause;
    } tri_word_t;

    typedef struct {
        logic [AREA_BITS-1:0] area;
        logic                 degen;
    } area_word_t;

    logic clk = 0;
    logic rst_n = 0;
    logic tri_valid = 0;
    logic tri_stall;
    logic [CB-1:0] ax = 0, ay = 0, az = 0, bx = 0, by_coord = 0, bz = 0, cx = 0, cy = 0, cz = 0;
    logic area_valid;
    logic area_stall = 0;
    logic [AREA_BITS-1:0] area;
    logic degenerate_base;

    tri_word_t  pending [$];
    area_word_t area_exp [$];
    tri_word_t  cur;
    int errors = 0;
    int cycles = 0;
    int cur_phase = 0;
    int idle_pct [4] = '{0, 57, 0, 23};
    int stall_pct [4] = '{0, 0, 57, 23};
    bit nv;

    triangle_area_3d uut (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall),
        .ax(ax), .ay(ay), .az(az), .bx(bx), .by_coord(by_coord), .bz(bz),
        .cx(cx), .cy(cy), .cz(cz),
        .area_valid(area_valid), .area_stall(area_stall),
        .area(area), .degenerate_base(degenerate_base)
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function automatic logic [127:0] mag(input longint c);
        return (c < 0) ? 128'(-c) : 128'(c);
    endfunction

    function automatic area_word_t triangle_area(input tri_word_t w);
        area_word_t r;
        longint q [9];
        longint u [3];
        longint v [3];
        longint cr [3];
        logic [127:0] s, root, t;
        for (int i = 0; i < 9; i++)
            q[i] = longint'($signed(w.p[i]));
        for (int i = 0; i < 3; i++)
        begin
            u[i] = q[i] - q[3 + i];
            v[i] = q[6 + i] - q[3 + i];
        end
        if (u[0] == 0 && u[1] == 0 && u[2] == 0)
        begin
            r.area = AREA_ONE;
            r.degen = 1'b1;
            return r;
        end
        cr[0] = u[1] * v[2] - u[2] * v[1];
        cr[1] = u[2] * v[0] - u[0] * v[2];
        cr[2] = u[0] * v[1] - u[1] * v[0];
        s = mag(cr[0]) * mag(cr[0]) + mag(cr[1]) * mag(cr[1]) + mag(cr[2]) * mag(cr[2]);
        root = 0;
        for (int b = 63; b >= 0; b--)
        begin
            t = root | (128'd1 << b);
            if (t * t <= s)
                root = t;
        end
        root = root >> 1;
        r.area = (root >> AREA_BITS) != 0 ? {AREA_BITS{1'b1}} : root[AREA_BITS-1:0];
        r.degen = 1'b0;
        return r;
    endfunction

    function automatic tri_word_t mk(input logic [CB-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2,
                                     input int ph, input bit ps);
        tri_word_t w;
        w.p = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        w.phase = ph;
        w.pause = ps;
        return w;
    endfunction

    function automatic logic [CB-1:0] rnd_coord(input int kind);
        if (kind == 0)
            return CB'($urandom);
        return CB'($signed($urandom_range(4000)) - 2000);
    endfunction

    function automatic tri_word_t rnd_tri(input int ph, input bit ps);
        tri_word_t w;
        int kind;
        int sel;
        logic [CB-1:0] d [3];
        sel = $urandom_range(99);
        kind = $urandom_range(1);
        for (int i = 0; i < 9; i++)
            w.p[i] = rnd_coord(kind);
        for (int i = 0; i < 3; i++)
            d[i] = rnd_coord(1);
        if (sel < 6)
        begin
            for (int i = 0; i < 3; i++)
                w.p[i] = w.p[3 + i];
        end
        else if (sel < 10)
        begin
            for (int i = 0; i < 3; i++)
                w.p[6 + i] = w.p[3 + i];
        end
        else if (sel < 16)
        begin
            for (int i = 0; i < 3; i++)
            begin
                w.p[i] = w.p[3 + i] + d[i];
                w.p[6 + i] = w.p[3 + i] - d[i] * CB'(sel - 9);
            end
        end
        w.phase = ph;
        w.pause = ps;
        return w;
    endfunction

    // driver: hold a stalled word, load the next one when free
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            nv = tri_valid;
            if (tri_valid && !tri_stall)
            begin
                area_exp.push_back(triangle_area(cur));
                nv = 0;
            end
            if (!nv && pending.size() > 0 && !(pending[0].pause && area_exp.size() != 0))
            begin
                if ($urandom_range(99) >= idle_pct[pending[0].phase] || pending[0].pause)
                begin
                    cur = pending.pop_front();
                    cur_phase <= cur.phase;
                    nv = 1;
                end
            end
            tri_valid <= nv;
            ax <= cur.p[0]; ay <= cur.p[1]; az <= cur.p[2];
            bx <= cur.p[3]; by_coord <= cur.p[4]; bz <= cur.p[5];
            cx <= cur.p[6]; cy <= cur.p[7]; cz <= cur.p[8];
        end
    end

    // monitor: compare each accepted area word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (area_valid && !area_stall)
            begin
                if (area_exp.size() == 0)
                begin
                    $display("%0t: unexpected area word %h degen %b", $time, area,
                             degenerate_base);
                    errors++;
                end
                else
                begin
                    area_word_t e;
                    e = area_exp.pop_front();
                    if (e.area !== area)
                    begin
                        $display("%0t: area expected %h actual %h", $time, e.area, area);
                        errors++;
                    end
                    if (e.degen !== degenerate_base)
                    begin
                        $display("%0t: degenerate_base expected %b actual %b", $time,
                                 e.degen, degenerate_base);
                        errors++;
                    end
                end
            end
            area_stall <= ($urandom_range(99) < stall_pct[cur_phase]);
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("[triangle_area_3d] ERROR");
            $finish;
        end
    end

    initial
    begin
        cur = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        pending.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending.push_back(mk(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, 0));
        pending.push_back(mk(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0));
        pending.push_back(mk(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, 0, 0));
        pending.push_back(mk(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, 0, 0));
        pending.push_back(mk(CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, 0, 0));
        pending.push_back(mk(CMAX, 0, 0, CMIN, 0, 0, 0, CMAX, 0, 0, 0));
        pending.push_back(mk(CMAX, CMAX, 0, CMIN, CMIN, 0, CMIN, CMAX, CMAX, 0, 0));
        pending.push_back(mk(256, 0, 0, 0, 0, 0, 0, 256, 0, 0, 0));
        pending.push_back(mk(0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0));
        pending.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        pending.push_back(mk(CMAX, 5, 7, 0, 0, 0, 0, 0, 0, 0, 0));
        pending.push_back(mk(10, 20, 30, 1, 2, 3, 1, 2, 3, 0, 0));
        pending.push_back(mk(2, 4, 6, 1, 2, 3, 3, 6, 9, 0, 0));
        pending.push_back(mk(CMAX, CMAX, CMAX, 0, 0, 0, CMIN, CMIN, CMIN, 0, 0));
        pending.push_back(mk(CMIN, 0, 0, CMAX, 0, 0, 1, 0, 0, 0, 0));
        pending.push_back(mk(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0,
                             24'hAAAAAA, 24'h555555, 24'hFFFFFF, 0, 0));
        pending.push_back(mk(24'h555555, 24'hAAAAAA, 24'h000001, 24'hAAAAAA, 24'h555555,
                             24'h123456, 24'hFEDCBA, 24'h0F0F0F, 24'hF0F0F0, 0, 0));
        for (int ph = 0; ph < 4; ph++)
            for (int i = 0; i < 425; i++)
                pending.push_back(rnd_tri(ph, i == 0 || i == 200));
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        wait (pending.size() == 0 && !tri_valid && area_exp.size() == 0);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("[triangle_area_3d] OK");
        else
            $display("[triangle_area_3d] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/ta3_pkg.sv
rtl/ta3_front.sv
rtl/ta3_sqrt_cell.sv
rtl/triangle_area_3d.sv
rtl/ta3_checker.sv
sim/tb_triangle_area_3d.sv
